@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// Plain text, no dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CKC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define CKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ src/ckc_pkg.sv @@
// Package for the cheapest-units cost tree: field widths, limits, op codes,
// sequencer states. No dependencies.
package ckc_pkg;

    localparam int unsigned PRICE_W          = 10;
    localparam int unsigned DELTA_W          = 32;
    localparam int unsigned CNT_W            = 32;
    localparam int unsigned COST_W           = 48;
    localparam int unsigned PRICE_LEVELS_DEF = 1024;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UDESC,
        S_ULEAF,
        S_UMUL,
        S_UWLEAF,
        S_USIB,
        S_QRD,
        S_QCHK,
        S_QLEFT,
        S_QMUL,
        S_QFIN,
        S_QOUT
    } t_state;

endpackage

@@ src/ckc_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on ckc_pkg for field widths.
interface ckc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [ckc_pkg::PRICE_W-1:0]         price;
    logic signed [ckc_pkg::DELTA_W-1:0]  delta;

    modport source(output valid, op, price, delta, input ready);
    modport sink(input valid, op, price, delta, output ready);
endinterface

interface ckc_out_if;
    logic                        valid;
    logic                        ready;
    logic [ckc_pkg::COST_W-1:0]  cost;

    modport source(output valid, cost, input ready);
    modport sink(input valid, cost, output ready);
endinterface

@@ src/cheapest_k_units_cost_tree_unit.sv @@
// Top level of the cheapest-units cost tree: sequencer, node RAM, shared ALU.
// Depends on ckc_pkg, ckc_if, ckc_ram, ckc_alu and assert_macros.svh.
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        op, price, delta
//   o_out    out  valid/ready        cost
//   cfg      in   i_cfg_we           i_cfg_wdata (units_wanted)
//
// An update or query walks the tree levels, log2(PRICE_LEVELS) deep (rounded up
// when PRICE_LEVELS is not a power of two), through the single read port of the
// node RAM; a new item is taken only in idle, once the last one is done.
// After reset the node RAM is swept to zero, one node a cycle, over all of its nodes;
// no item is taken meanwhile. A finished query result waits in an output register;
// a later query holds in its last step until that result is taken.
`include "assert_macros.svh"

module cheapest_k_units_cost_tree_unit #(
    parameter int unsigned PRICE_LEVELS = ckc_pkg::PRICE_LEVELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ckc_in_if.sink                    i_in,
    ckc_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [ckc_pkg::CNT_W-1:0] i_cfg_wdata
);

    localparam int unsigned LW         = $clog2(PRICE_LEVELS);
    localparam bit          POW2       = (PRICE_LEVELS & (PRICE_LEVELS - 1)) == 0;
    localparam int unsigned NODE_DEPTH = POW2 ? 2 * PRICE_LEVELS : 4 * PRICE_LEVELS;
    localparam int unsigned AW         = $clog2(NODE_DEPTH);
    localparam int unsigned MW         = (LW > ckc_pkg::PRICE_W) ? LW : ckc_pkg::PRICE_W;
    localparam int unsigned PW         = ckc_pkg::CNT_W + MW;
    localparam int unsigned BW         = (PW > ckc_pkg::COST_W) ? PW : ckc_pkg::COST_W;
    localparam int unsigned DW         = ckc_pkg::CNT_W + ckc_pkg::COST_W;

    ckc_pkg::t_state r_state, n_state;

    logic [AW-1:0]                      r_node, n_node;
    logic [LW-1:0]                      r_lo, n_lo;
    logic [LW-1:0]                      r_hi, n_hi;
    logic                               r_op, n_op;
    logic [ckc_pkg::PRICE_W-1:0]        r_price, n_price;
    logic signed [ckc_pkg::DELTA_W-1:0] r_delta, n_delta;
    logic [ckc_pkg::CNT_W-1:0]          r_k, n_k;
    logic [ckc_pkg::COST_W-1:0]         r_ans, n_ans;
    logic [ckc_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [ckc_pkg::COST_W-1:0]         r_cost, n_cost;
    logic [PW-1:0]                      r_prod, n_prod;
    logic                               r_out_valid, n_out_valid;
    logic [ckc_pkg::COST_W-1:0]         r_out_cost, n_out_cost;
    logic [ckc_pkg::CNT_W-1:0]          r_units_wanted;

    logic                               in_acc;
    logic                               price_ok;
    logic [LW-1:0]                      mid;
    logic [AW-1:0]                      left;
    logic [AW-1:0]                      right;
    logic [AW-1:0]                      parent;
    logic                               ram_we;
    logic [AW-1:0]                      wr_addr;
    logic [DW-1:0]                      wr_data;
    logic [AW-1:0]                      rd_addr;
    logic [DW-1:0]                      rd_data;
    logic [ckc_pkg::CNT_W-1:0]          rd_cnt;
    logic [ckc_pkg::COST_W-1:0]         rd_cost;
    logic signed [ckc_pkg::CNT_W+1:0]   leaf_sum;
    logic [ckc_pkg::CNT_W-1:0]          leaf_cnt;
    logic [ckc_pkg::CNT_W-1:0]          mul_a;
    logic [MW-1:0]                      mul_b;
    logic [PW-1:0]                      prod;
    logic [ckc_pkg::CNT_W-1:0]          cnt_sum;
    logic [ckc_pkg::COST_W-1:0]         cost_a;
    logic [BW-1:0]                      cost_b;
    logic [ckc_pkg::COST_W-1:0]         cost_sum;

    ckc_ram #(
        .WIDTH (DW),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ckc_alu #(
        .MW (MW),
        .PW (PW),
        .BW (BW)
    ) u_alu (
        .i_mul_a    (mul_a),
        .i_mul_b    (mul_b),
        .o_prod     (prod),
        .i_cnt_a    (r_cnt),
        .i_cnt_b    (rd_cnt),
        .o_cnt_sum  (cnt_sum),
        .i_cost_a   (cost_a),
        .i_cost_b   (cost_b),
        .o_cost_sum (cost_sum)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign price_ok = 32'(i_in.price) < 32'(PRICE_LEVELS);
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign left     = AW'({r_node, 1'b0});
    assign right    = left | AW'(1);
    assign parent   = r_node >> 1;
    assign rd_cnt   = rd_data[DW-1:ckc_pkg::COST_W];
    assign rd_cost  = rd_data[ckc_pkg::COST_W-1:0];

    // leaf count plus signed delta, clamped to [0, CNT_MAX]
    assign leaf_sum = $signed({2'b00, rd_cnt}) + (ckc_pkg::CNT_W+2)'(r_delta);
    assign leaf_cnt = leaf_sum[ckc_pkg::CNT_W+1] ? '0 :
                      leaf_sum[ckc_pkg::CNT_W]   ? ckc_pkg::CNT_MAX :
                      leaf_sum[ckc_pkg::CNT_W-1:0];

    assign mul_a  = (r_op == ckc_pkg::OP_QUERY) ? r_k : r_cnt;
    assign mul_b  = (r_op == ckc_pkg::OP_QUERY) ? MW'(r_lo) : MW'(r_price);
    assign cost_a = (r_op == ckc_pkg::OP_QUERY) ? r_ans : r_cost;
    assign cost_b = (r_state == ckc_pkg::S_QFIN) ? BW'(r_prod) : BW'(rd_cost);

    assign i_in.ready  = (r_state == ckc_pkg::S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.cost  = r_out_cost;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ckc_pkg::S_CLEAR: begin
                if (r_node == AW'(NODE_DEPTH - 1)) begin
                    n_state = ckc_pkg::S_IDLE;
                end
            end
            ckc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == ckc_pkg::OP_QUERY) begin
                        n_state = ckc_pkg::S_QRD;
                    end else if (price_ok) begin
                        n_state = ckc_pkg::S_UDESC;
                    end
                end
            end
            ckc_pkg::S_UDESC: begin
                if (r_lo >= r_hi) begin
                    n_state = ckc_pkg::S_ULEAF;
                end
            end
            ckc_pkg::S_ULEAF:  n_state = ckc_pkg::S_UMUL;
            ckc_pkg::S_UMUL:   n_state = ckc_pkg::S_UWLEAF;
            ckc_pkg::S_UWLEAF: n_state = (r_node == AW'(1)) ? ckc_pkg::S_IDLE
                                                              : ckc_pkg::S_USIB;
            ckc_pkg::S_USIB: begin
                if (parent == AW'(1)) begin
                    n_state = ckc_pkg::S_IDLE;
                end
            end
            ckc_pkg::S_QRD:    n_state = ckc_pkg::S_QCHK;
            ckc_pkg::S_QCHK: begin
                if (rd_cnt <= r_k) begin
                    n_state = ckc_pkg::S_QOUT;
                end else if (r_lo >= r_hi) begin
                    n_state = ckc_pkg::S_QMUL;
                end else begin
                    n_state = ckc_pkg::S_QLEFT;
                end
            end
            ckc_pkg::S_QLEFT:  n_state = ckc_pkg::S_QCHK;
            ckc_pkg::S_QMUL:   n_state = ckc_pkg::S_QFIN;
            ckc_pkg::S_QFIN:   n_state = ckc_pkg::S_QOUT;
            ckc_pkg::S_QOUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ckc_pkg::S_IDLE;
                end
            end
            default:           n_state = ckc_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_node      = r_node;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_op        = r_op;
        n_price     = r_price;
        n_delta     = r_delta;
        n_k         = r_k;
        n_ans       = r_ans;
        n_cnt       = r_cnt;
        n_cost      = r_cost;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_cost  = r_out_cost;
        rd_addr     = r_node;
        ram_we      = 1'b0;
        wr_addr     = r_node;
        wr_data     = '0;
        case (r_state)
            ckc_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_node = r_node + AW'(1);
            end
            ckc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_in.op;
                    n_price = i_in.price;
                    n_delta = i_in.delta;
                    n_node  = AW'(1);
                    n_lo    = '0;
                    n_hi    = LW'(PRICE_LEVELS - 1);
                    n_k     = r_units_wanted;
                    n_ans   = '0;
                end
            end
            ckc_pkg::S_UDESC: begin
                if (r_lo < r_hi) begin
                    if (MW'(r_price) <= MW'(mid)) begin
                        n_node = left;
                        n_hi   = mid;
                    end else begin
                        n_node = right;
                        n_lo   = mid + LW'(1);
                    end
                end
            end
            ckc_pkg::S_ULEAF: begin
                n_cnt = leaf_cnt;
            end
            ckc_pkg::S_UMUL: begin
                n_prod = prod;
            end
            ckc_pkg::S_UWLEAF: begin
                ram_we  = 1'b1;
                wr_data = {r_cnt, ckc_pkg::COST_W'(r_prod)};
                n_cost  = ckc_pkg::COST_W'(r_prod);
                rd_addr = r_node ^ AW'(1);
            end
            ckc_pkg::S_USIB: begin
                ram_we  = 1'b1;
                wr_addr = parent;
                wr_data = {cnt_sum, cost_sum};
                n_cnt   = cnt_sum;
                n_cost  = cost_sum;
                n_node  = parent;
                rd_addr = parent ^ AW'(1);
            end
            ckc_pkg::S_QRD: begin
                rd_addr = r_node;
            end
            ckc_pkg::S_QCHK: begin
                if (rd_cnt <= r_k) begin
                    n_ans = cost_sum;
                end else begin
                    rd_addr = left;
                end
            end
            ckc_pkg::S_QLEFT: begin
                if (r_k <= rd_cnt) begin
                    n_node  = left;
                    n_hi    = mid;
                    rd_addr = left;
                end else begin
                    n_ans   = cost_sum;
                    n_k     = r_k - rd_cnt;
                    n_node  = right;
                    n_lo    = mid + LW'(1);
                    rd_addr = right;
                end
            end
            ckc_pkg::S_QMUL: begin
                n_prod = prod;
            end
            ckc_pkg::S_QFIN: begin
                n_ans = cost_sum;
            end
            ckc_pkg::S_QOUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cost  = r_ans;
                end
            end
            default: begin
                n_node = r_node;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ckc_pkg::S_CLEAR;
            r_node         <= '0;
            r_out_valid    <= 1'b0;
            r_units_wanted <= '0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_units_wanted <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_op       <= n_op;
        r_price    <= n_price;
        r_delta    <= n_delta;
        r_k        <= n_k;
        r_ans      <= n_ans;
        r_cnt      <= n_cnt;
        r_cost     <= n_cost;
        r_prod     <= n_prod;
        r_out_cost <= n_out_cost;
    end

    `CKC_ASSERT_NEXT(a_query_start, i_clk, i_rst_n, in_acc && i_in.op == ckc_pkg::OP_QUERY, r_state == ckc_pkg::S_QRD)
    `CKC_ASSERT_SAME(a_no_root_parent, i_clk, i_rst_n, ram_we && r_state != ckc_pkg::S_CLEAR, wr_addr != '0)
    `CKC_ASSERT_SAME(a_ascent_below_root, i_clk, i_rst_n, r_state == ckc_pkg::S_USIB, r_node > AW'(1))
    `CKC_ASSERT_SAME(a_result_from_query, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ckc_pkg::S_QOUT)

endmodule

@@ src/ckc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ckc_alu.sv @@
// Shared arithmetic unit: one multiplier plus a saturating count/cost adder pair.
// Depends on ckc_pkg for widths and saturation limits.
module ckc_alu #(
    parameter int unsigned MW = ckc_pkg::PRICE_W,
    parameter int unsigned PW = ckc_pkg::CNT_W + MW,
    parameter int unsigned BW = (PW > ckc_pkg::COST_W) ? PW : ckc_pkg::COST_W
) (
    input  logic [ckc_pkg::CNT_W-1:0]  i_mul_a,
    input  logic [MW-1:0]              i_mul_b,
    output logic [PW-1:0]              o_prod,
    input  logic [ckc_pkg::CNT_W-1:0]  i_cnt_a,
    input  logic [ckc_pkg::CNT_W-1:0]  i_cnt_b,
    output logic [ckc_pkg::CNT_W-1:0]  o_cnt_sum,
    input  logic [ckc_pkg::COST_W-1:0] i_cost_a,
    input  logic [BW-1:0]              i_cost_b,
    output logic [ckc_pkg::COST_W-1:0] o_cost_sum
);

    logic [ckc_pkg::CNT_W:0] cnt_full;
    logic [BW:0]             cost_full;

    assign o_prod    = PW'(i_mul_a) * PW'(i_mul_b);
    assign cnt_full  = {1'b0, i_cnt_a} + {1'b0, i_cnt_b};
    assign o_cnt_sum = cnt_full[ckc_pkg::CNT_W] ? ckc_pkg::CNT_MAX
                                                : cnt_full[ckc_pkg::CNT_W-1:0];
    assign cost_full  = (BW+1)'(i_cost_a) + (BW+1)'(i_cost_b);
    assign o_cost_sum = (cost_full > (BW+1)'(ckc_pkg::COST_MAX)) ? ckc_pkg::COST_MAX
                                                                 : cost_full[ckc_pkg::COST_W-1:0];

endmodule

@@ verif/ckc_cost_checker.sv @@
// Checker for the cheapest-units cost tree: watches the item channels and the
// config port, keeps its own copy of the count/cost tree and checks each cost.
// Depends on ckc_pkg and ckc_if.
module ckc_cost_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ckc_in_if                         in_mon,
    ckc_out_if                        out_mon,
    input  logic                      i_cfg_we,
    input  logic [ckc_pkg::CNT_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int unsigned LEVELS = ckc_pkg::PRICE_LEVELS_DEF;
    localparam int unsigned NODES  = 2 * LEVELS;

    logic [ckc_pkg::CNT_W-1:0]  unit_cnt [NODES];
    logic [ckc_pkg::COST_W-1:0] cost_sum [NODES];
    logic [ckc_pkg::CNT_W-1:0]  units_wanted_q;
    logic [ckc_pkg::COST_W-1:0] cost_due [$];
    int                         fail_count;

    function automatic logic [ckc_pkg::COST_W-1:0] add_cost_sat(
        logic [ckc_pkg::COST_W-1:0] a,
        logic [ckc_pkg::COST_W-1:0] b);
        logic [ckc_pkg::COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ckc_pkg::COST_W] ? ckc_pkg::COST_MAX : s[ckc_pkg::COST_W-1:0];
    endfunction

    function automatic void apply_delta(logic [ckc_pkg::PRICE_W-1:0] price,
                                        logic signed [ckc_pkg::DELTA_W-1:0] delta);
        int unsigned path [32];
        int          depth;
        int unsigned node, lo, hi, mid;
        longint      c;
        logic [ckc_pkg::CNT_W:0] cs;
        node  = 1;
        lo    = 0;
        hi    = LEVELS - 1;
        depth = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            path[depth] = node;
            depth++;
            if (price <= mid) begin
                node = 2 * node;
                hi   = mid;
            end else begin
                node = 2 * node + 1;
                lo   = mid + 1;
            end
        end
        c = longint'({1'b0, unit_cnt[node]}) + longint'(delta);
        if (c < 0)
            c = 0;
        if (c > longint'(64'hFFFF_FFFF))
            c = longint'(64'hFFFF_FFFF);
        unit_cnt[node] = c[ckc_pkg::CNT_W-1:0];
        cost_sum[node] = ckc_pkg::COST_W'(c * longint'({1'b0, price}));
        while (depth > 0) begin
            depth--;
            node = path[depth];
            cs = {1'b0, unit_cnt[2*node]} + {1'b0, unit_cnt[2*node+1]};
            unit_cnt[node] = cs[ckc_pkg::CNT_W] ? ckc_pkg::CNT_MAX : cs[ckc_pkg::CNT_W-1:0];
            cost_sum[node] = add_cost_sat(cost_sum[2*node], cost_sum[2*node+1]);
        end
    endfunction

    // walk down from the root, taking whole left subtrees while they fit
    function automatic logic [ckc_pkg::COST_W-1:0] cheapest_cost();
        int unsigned                node, lo, hi, mid, left;
        logic [63:0]                want;
        logic [ckc_pkg::COST_W-1:0] acc, result;
        bit                         done;
        node   = 1;
        lo     = 0;
        hi     = LEVELS - 1;
        want   = {32'b0, units_wanted_q};
        acc    = '0;
        result = '0;
        done   = 1'b0;
        while (!done) begin
            if ({32'b0, unit_cnt[node]} <= want) begin
                result = add_cost_sat(acc, cost_sum[node]);
                done   = 1'b1;
            end else if (lo >= hi) begin
                result = add_cost_sat(acc, ckc_pkg::COST_W'(want * lo));
                done   = 1'b1;
            end else begin
                mid  = lo + (hi - lo) / 2;
                left = 2 * node;
                if (want <= {32'b0, unit_cnt[left]}) begin
                    node = left;
                    hi   = mid;
                end else begin
                    acc  = add_cost_sat(acc, cost_sum[left]);
                    want = want - {32'b0, unit_cnt[left]};
                    node = left + 1;
                    lo   = mid + 1;
                end
            end
        end
        return result;
    endfunction

    initial fail_count = 0;

    always @(posedge i_clk) begin
        logic [ckc_pkg::COST_W-1:0] want_cost;
        if (!i_rst_n) begin
            for (int n = 0; n < NODES; n++) begin
                unit_cnt[n] = '0;
                cost_sum[n] = '0;
            end
            units_wanted_q = '0;
            cost_due.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                if (cost_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("cost %0d arrived with no query outstanding", out_mon.cost);
                    fail_count++;
                end else begin
                    want_cost = cost_due.pop_front();
                    if (out_mon.cost !== want_cost) begin
                        if (fail_count < 10)
                            $display("cost mismatch: expected %0d, got %0d",
                                     want_cost, out_mon.cost);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                if (in_mon.op == ckc_pkg::OP_QUERY)
                    cost_due.insert(cost_due.size(), cheapest_cost());
                else
                    apply_delta(in_mon.price, in_mon.delta);
            end
            if (i_cfg_we)
                units_wanted_q = i_cfg_wdata;
        end
        o_pending    = cost_due.size();
        o_fail_count = fail_count;
    end

endmodule

@@ verif/testbench.sv @@
// Top of the cost tree testbench: clock, reset, bursty item stimulus, result
// back-pressure, units_wanted settings and the verdict.
// Depends on ckc_pkg, ckc_if, ckc_cost_checker and the cost tree RTL.
module testbench;

    localparam int IDLE_LIMIT    = 10000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic signed [ckc_pkg::DELTA_W-1:0] DELTA_MIN = 32'sh8000_0000;
    localparam logic signed [ckc_pkg::DELTA_W-1:0] DELTA_MAX = 32'sh7FFF_FFFF;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} t_sink_mode;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [ckc_pkg::CNT_W-1:0] i_cfg_wdata;
    int                        fail_count;
    int                        pending;

    int          burst_left  = 0;
    bit          steady      = 1'b0;
    int          n_update    = 0;
    int          n_query     = 0;
    int          n_settings  = 0;
    int          idle_cycles = 0;
    int unsigned stall_cycle = 0;
    t_sink_mode  sink_mode   = SINK_OPEN;

    ckc_in_if  in_ch ();
    ckc_out_if out_ch ();

    cheapest_k_units_cost_tree_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ckc_cost_checker cost_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result back-pressure
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 300 == 0)
            sink_mode = t_sink_mode'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:     out_ch.ready <= 1'b1;
            SINK_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: out_ch.ready <= (stall_cycle % 16 == 15);
            default:       out_ch.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles", IDLE_LIMIT);
            $display("** cheapest_k_units_cost_tree_unit: FAILED **");
            $finish;
        end
    end

    task automatic push_item(input logic op, input logic [ckc_pkg::PRICE_W-1:0] price,
                             input logic signed [ckc_pkg::DELTA_W-1:0] delta);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.price <= price;
        in_ch.delta <= delta;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        if (op == ckc_pkg::OP_QUERY)
            n_query++;
        else
            n_update++;
    endtask

    task automatic ask();
        push_item(ckc_pkg::OP_QUERY, ckc_pkg::PRICE_W'($urandom()),
                  ckc_pkg::DELTA_W'($urandom()));
    endtask

    // no new items, all costs back, then room for a trailing update
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_units_wanted(input logic [ckc_pkg::CNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int                                 len, window, roll, d;
        logic [ckc_pkg::PRICE_W-1:0]        price;
        logic signed [ckc_pkg::DELTA_W-1:0] delta;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_ch.valid  = 1'b0;
        in_ch.op     = ckc_pkg::OP_UPDATE;
        in_ch.price  = '0;
        in_ch.delta  = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tree, zero k, clamp, saturation, field extremes
        set_units_wanted(32'd0);
        ask();
        push_item(ckc_pkg::OP_UPDATE, 10'd5, 32'sd3);
        ask();
        set_units_wanted(32'd5);
        ask();
        push_item(ckc_pkg::OP_UPDATE, 10'd0, 32'sd3);
        push_item(ckc_pkg::OP_UPDATE, 10'd1023, 32'sd2);
        push_item(ckc_pkg::OP_UPDATE, 10'd512, -32'sd5);
        push_item(ckc_pkg::OP_UPDATE, 10'd7, 32'sd4);
        ask();
        push_item(ckc_pkg::OP_UPDATE, 10'd5, DELTA_MIN);
        push_item(ckc_pkg::OP_UPDATE, 10'd1023, DELTA_MAX);
        push_item(ckc_pkg::OP_UPDATE, 10'd1023, DELTA_MAX);
        push_item(ckc_pkg::OP_UPDATE, 10'd1022, DELTA_MAX);
        ask();
        set_units_wanted(ckc_pkg::CNT_MAX);
        ask();
        push_item(ckc_pkg::OP_UPDATE, 10'd512, 32'sd1);
        push_item(ckc_pkg::OP_UPDATE, 10'd1023, -32'sd1);
        ask();
        set_units_wanted(32'd1);
        ask();
        push_item(ckc_pkg::OP_UPDATE, 10'd0, DELTA_MIN);
        ask();

        // random phases; phase 5 floods the top prices to saturate costs
        for (int phase = 0; phase < 9; phase++) begin
            case (phase == 6 ? 3 : $urandom_range(0, 5))
                0:       set_units_wanted(32'd0);
                1:       set_units_wanted(ckc_pkg::CNT_W'($urandom_range(1, 16)));
                2:       set_units_wanted(ckc_pkg::CNT_W'($urandom_range(0, 2000)));
                3:       set_units_wanted(ckc_pkg::CNT_MAX);
                4:       set_units_wanted(ckc_pkg::CNT_W'($urandom()));
                default: set_units_wanted(ckc_pkg::CNT_W'($urandom_range(2000, 200000)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            window = $urandom_range(0, 1023 - 31);
            len    = (phase < 5) ? 110 : (phase == 5) ? 300 : 100;
            for (int j = 0; j < len; j++) begin
                if (phase == 5 && j < 256) begin
                    push_item(ckc_pkg::OP_UPDATE, ckc_pkg::PRICE_W'(896 + j / 2), DELTA_MAX);
                end else if ($urandom_range(0, 3) == 0) begin
                    ask();
                end else begin
                    roll  = $urandom_range(0, 9);
                    price = ($urandom_range(0, 1) == 0)
                          ? ckc_pkg::PRICE_W'(window + $urandom_range(0, 31))
                          : ckc_pkg::PRICE_W'($urandom());
                    if (roll < 7) begin
                        d     = int'($urandom_range(0, 24)) - 6;
                        delta = ckc_pkg::DELTA_W'(d);
                    end else if (roll < 9) begin
                        delta = ckc_pkg::DELTA_W'($urandom());
                    end else begin
                        delta = DELTA_MIN;
                    end
                    push_item(ckc_pkg::OP_UPDATE, price, delta);
                end
            end
        end

        settle();
        $display("Covered %0d updates and %0d queries over %0d units_wanted settings,",
                 n_update, n_query, n_settings);
        $display("including clamped removals and saturated counts and costs.");
        if (fail_count == 0 && pending == 0) begin
            $display("** cheapest_k_units_cost_tree_unit: PASSED **");
        end else begin
            $display("** cheapest_k_units_cost_tree_unit: FAILED **");
        end
        $finish;
    end

endmodule
